FILE: rtl/byte_ring_fifo_multibyte_assert.svh
// Assertion macros for the checker module.
`ifndef BYTE_RING_FIFO_MULTIBYTE_ASSERT_SVH
`define BYTE_RING_FIFO_MULTIBYTE_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled in reset.
`define BRFM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("brfm assertion failed");

// Next-cycle implication, sampled on aclk and disabled in reset.
`define BRFM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("brfm assertion failed");

`endif

FILE: rtl/brfm_pkg.sv
package brfm_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_XFER = 8;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (MAX_XFER > 1) ? $clog2(MAX_XFER) : 1;

    localparam int TYPE_W = 2;
    localparam int LEN_W  = 4;
    localparam int WDAT_W = 64;
    localparam int STAT_W = 2;
    localparam int BYTE_W = 8;
    localparam int FILL_W = 11;

    localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_PEEK  = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_SKIP  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOROOM  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  byte_count;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } res_t;

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [LEN_W-1:0] offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + (ADDR_W + 1)'(offset);
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/brfm_ram.sv
module brfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/brfm_ctrl.sv
module brfm_ctrl
    import brfm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TYPE_W-1:0] in_type,
    input  logic [LEN_W-1:0]  in_len,
    input  logic [WDAT_W-1:0] in_data,
    input  logic              out_free,
    output logic              res_load,
    output res_t              res,
    output mem_req_t          mem_req,
    input  logic [BYTE_W-1:0] mem_rdata
);

    state_t              state_reg, state_next;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [WDAT_W-1:0]   data_reg, data_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    held_reg, held_next;

    logic                len_bad;
    logic                no_room;
    logic [LEN_W-1:0]    count_avail;
    logic                idx_last;
    logic [ADDR_W-1:0]   addr_inc;
    logic [CNT_W-1:0]    held_after_read;

    assign len_bad = (len_reg == '0) || (len_reg > LEN_W'(MAX_XFER));
    assign no_room = ({1'b0, held_reg} + (CNT_W + 1)'(len_reg)) > (CNT_W + 1)'(DEPTH);
    assign count_avail = (held_reg < CNT_W'(len_reg)) ? LEN_W'(held_reg) : len_reg;
    assign idx_last = (LEN_W'(idx_reg) == (count_reg - LEN_W'(1)));
    assign addr_inc = wrap_add(addr_reg, LEN_W'(1));
    assign held_after_read = held_reg - CNT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            held_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg   <= type_next;
        len_reg    <= len_next;
        data_reg   <= data_next;
        idx_reg    <= idx_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    always_comb begin
        state_next  = state_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        held_next   = held_reg;

        in_ready = 1'b0;
        res_load = 1'b0;
        res      = '0;
        mem_req  = '0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    type_next  = in_type;
                    len_next   = in_len;
                    data_next  = in_data;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                idx_next    = '0;
                status_next = STAT_OK;
                if (len_bad) begin
                    status_next = STAT_BAD_LEN;
                    count_next  = '0;
                    state_next  = ST_RESP;
                end else if (type_reg == REQ_WRITE) begin
                    if (no_room) begin
                        status_next = STAT_NOROOM;
                        count_next  = '0;
                        state_next  = ST_RESP;
                    end else begin
                        count_next = len_reg;
                        addr_next  = wr_ptr_reg;
                        state_next = ST_WRITE;
                    end
                end else if (held_reg == '0) begin
                    status_next = STAT_NOROOM;
                    count_next  = '0;
                    state_next  = ST_RESP;
                end else if (type_reg == REQ_SKIP) begin
                    count_next  = count_avail;
                    rd_ptr_next = wrap_add(rd_ptr_reg, count_avail);
                    held_next   = held_reg - CNT_W'(count_avail);
                    state_next  = ST_RESP;
                end else begin
                    count_next    = count_avail;
                    addr_next     = rd_ptr_reg;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rd_ptr_reg;
                    state_next    = ST_READ;
                end
            end
            ST_WRITE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = addr_reg;
                mem_req.wdata = data_reg[BYTE_W-1:0];
                data_next     = data_reg >> BYTE_W;
                idx_next      = idx_reg + IDX_W'(1);
                addr_next     = addr_inc;
                if (idx_last) begin
                    wr_ptr_next = addr_inc;
                    held_next   = held_reg + CNT_W'(count_reg);
                    state_next  = ST_RESP;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    res_load       = 1'b1;
                    res.status     = STAT_OK;
                    res.data_byte  = mem_rdata;
                    res.byte_count = count_reg;
                    res.last       = idx_last;
                    res.fill_level = (type_reg == REQ_READ) ? FILL_W'(held_after_read)
                                                            : FILL_W'(held_reg);
                    if (idx_last) begin
                        if (type_reg == REQ_READ) begin
                            rd_ptr_next = addr_inc;
                            held_next   = held_after_read;
                        end
                        state_next = ST_IDLE;
                    end else begin
                        idx_next      = idx_reg + IDX_W'(1);
                        addr_next     = addr_inc;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = addr_inc;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    res_load       = 1'b1;
                    res.status     = status_reg;
                    res.byte_count = count_reg;
                    res.last       = 1'b1;
                    res.fill_level = FILL_W'(held_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/byte_ring_fifo_multibyte.sv
// Circular byte queue of 1024 bytes driven by one request per input beat.
// The s_ channel carries a request: s_tuser holds the kind (write, read,
// peek or skip) and s_tdata the length and up to eight bytes of write data.
// The m_ channel returns result beats: one beat for a write, a skip or any
// error, and one beat per byte for a read or a peek, with m_tlast on the
// final beat of the request. Every beat reports the fill level after the
// request.
// A request is decoded in the cycle after it is accepted. A write then
// stores one byte per cycle and answers once its last byte is stored. A
// read or peek streams one byte per cycle from the byte memory's single
// read port while the output register is free. s_tready is high only
// while no request is in progress.
// Results leave through a single output register, so the next request can
// be accepted while the last beat still waits. When the receiver stalls,
// the sequencer holds its place and the beat on m_tdata stays put.
// Reset empties the queue and clears both pointers; the byte memory itself
// is not cleared.
module byte_ring_fifo_multibyte
    import brfm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // req_len[3:0], write_data[67:4], zero pad
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // data_byte[7:0], byte_count[11:8], fill_level[22:12], pad
    output logic [1:0]  m_tuser,  // status[1:0]
    output logic        m_tlast
);

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    logic              res_load;
    res_t              res;
    logic              out_free;
    logic              m_valid_reg;
    res_t              m_res_reg;

    assign out_free = !m_valid_reg || m_tready;

    brfm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_len    (s_tdata[LEN_W-1:0]),
        .in_data   (s_tdata[LEN_W+WDAT_W-1:LEN_W]),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    brfm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.fill_level, m_res_reg.byte_count, m_res_reg.data_byte};
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;

endmodule

FILE: rtl/brfm_checker.sv
`include "byte_ring_fifo_multibyte_assert.svh"

module brfm_checker
    import brfm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `BRFM_ASSERT_NXT(a_out_hold,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    `BRFM_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    `BRFM_ASSERT_IMP(a_error_single_beat,
        m_tvalid && (m_tuser != STAT_OK),
        m_tlast && (m_tdata[11:0] == 12'd0))

    `BRFM_ASSERT_IMP(a_fill_bounded, m_tvalid, m_tdata[22:12] <= FILL_W'(DEPTH))

endmodule

bind byte_ring_fifo_multibyte brfm_checker u_brfm_checker (.*);

FILE: dv/tb_byte_ring_fifo_multibyte.sv
`timescale 1ns / 1ps

module tb_byte_ring_fifo_multibyte;
    import brfm_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int RANDOM_REQS = 480;
    localparam int CALM_FROM   = 420;
    localparam int HOLD_CYCLES = 400;

    class fifo_scoreboard;
        logic [7:0]  bytes_q [DEPTH];
        int unsigned rd_ptr;
        int unsigned wr_ptr;
        int unsigned held;
        res_t        pending [$];
        int          errors;
        int          beats;
        int          n_kind [4];
        int          n_bad_len;
        int          n_refused;
        int          n_empty;
        int          n_full;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            held = 0;
            errors = 0;
            beats = 0;
            n_bad_len = 0;
            n_refused = 0;
            n_empty = 0;
            n_full = 0;
            foreach (n_kind[k]) n_kind[k] = 0;
        endfunction

        function void push_beat(logic [1:0] st, logic [7:0] db, logic [3:0] cnt, logic lst);
            res_t r;
            r.status     = st;
            r.data_byte  = db;
            r.byte_count = cnt;
            r.last       = lst;
            r.fill_level = FILL_W'(held);
            pending.push_back(r);
        endfunction

        function void note_request(logic [1:0] kind, logic [3:0] len, logic [63:0] wdat);
            int unsigned cnt;
            int unsigned start;
            n_kind[kind]++;
            if (len == 0 || len > MAX_XFER) begin
                n_bad_len++;
                push_beat(STAT_BAD_LEN, 8'd0, 4'd0, 1'b1);
                return;
            end
            if (kind == REQ_WRITE) begin
                if (held + len > DEPTH) begin
                    n_refused++;
                    push_beat(STAT_NOROOM, 8'd0, 4'd0, 1'b1);
                    return;
                end
                for (int i = 0; i < len; i++) begin
                    bytes_q[(wr_ptr + i) % DEPTH] = wdat[8*i +: 8];
                end
                wr_ptr = (wr_ptr + len) % DEPTH;
                held += len;
                if (held == DEPTH) n_full++;
                push_beat(STAT_OK, 8'd0, len, 1'b1);
                return;
            end
            if (held == 0) begin
                n_empty++;
                push_beat(STAT_NOROOM, 8'd0, 4'd0, 1'b1);
                return;
            end
            cnt = (held < len) ? held : len;
            start = rd_ptr;
            if (kind != REQ_PEEK) begin
                rd_ptr = (rd_ptr + cnt) % DEPTH;
                held -= cnt;
            end
            if (kind == REQ_SKIP) begin
                push_beat(STAT_OK, 8'd0, 4'(cnt), 1'b1);
                return;
            end
            for (int i = 0; i < cnt; i++) begin
                push_beat(STAT_OK, bytes_q[(start + i) % DEPTH], 4'(cnt), i + 1 == cnt);
            end
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            beats++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result beat: status %0d data %02h count %0d last %0d fill %0d",
                             got.status, got.data_byte, got.byte_count, got.last, got.fill_level);
                end
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10) begin
                    $display("Beat %0d differs: expected status %0d data %02h count %0d last %0d fill %0d",
                             beats, exp_r.status, exp_r.data_byte, exp_r.byte_count,
                             exp_r.last, exp_r.fill_level);
                    $display("             got      status %0d data %02h count %0d last %0d fill %0d",
                             got.status, got.data_byte, got.byte_count, got.last, got.fill_level);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;  // req_len[3:0], write_data[67:4], zero pad
    logic [1:0]  s_tuser  = '0;  // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // data_byte[7:0], byte_count[11:8], fill_level[22:12], pad
    logic [1:0]  m_tuser;        // status[1:0]
    logic        m_tlast;

    fifo_scoreboard sb = new();
    bit          calm = 1'b0;
    int          cycles = 0;
    int          sent = 0;

    byte_ring_fifo_multibyte uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = m_tuser;
            got.data_byte  = m_tdata[7:0];
            got.byte_count = m_tdata[11:8];
            got.last       = m_tlast;
            got.fill_level = m_tdata[22:12];
            sb.check_result(got);
        end
    end

    // Receiver: random stalls, one long hold-off that backs the block up.
    initial begin
        bit held_off;
        held_off = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (!held_off && sb.beats >= 60) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    task automatic send_req(logic [1:0] kind, logic [3:0] len, logic [63:0] wdat);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, wdat, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(kind, len, wdat);
        sent++;
    endtask

    initial begin
        logic [1:0]  kind;
        logic [3:0]  len;
        logic [63:0] wdat;
        bit          filling;
        int          pick;

        filling = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue, bad lengths, then short and full-width writes mixed with reads, peeks and skips.
        send_req(REQ_READ,  4'd4,  64'h0);
        send_req(REQ_PEEK,  4'd1,  64'h0);
        send_req(REQ_SKIP,  4'd8,  64'h0);
        send_req(REQ_WRITE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_WRITE, 4'd9,  64'h0123_4567_89AB_CDEF);
        send_req(REQ_READ,  4'd15, 64'h0);
        send_req(REQ_PEEK,  4'd12, 64'h0);
        send_req(REQ_SKIP,  4'd10, 64'h0);
        send_req(REQ_WRITE, 4'd1,  64'h0000_0000_0000_00FF);
        send_req(REQ_WRITE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_WRITE, 4'd8,  64'h0);
        send_req(REQ_WRITE, 4'd3,  {$urandom, $urandom});
        send_req(REQ_PEEK,  4'd8,  64'h0);
        send_req(REQ_READ,  4'd8,  64'h0);
        send_req(REQ_SKIP,  4'd2,  64'h0);
        send_req(REQ_PEEK,  4'd8,  64'h0);
        send_req(REQ_READ,  4'd8,  64'h0);
        send_req(REQ_PEEK,  4'd8,  64'h0);
        send_req(REQ_READ,  4'd8,  64'h0);
        send_req(REQ_SKIP,  4'd5,  64'h0);
        send_req(REQ_WRITE, 4'd5,  64'h8000_00AA_5555_AA01);
        send_req(REQ_SKIP,  4'd8,  64'h0);
        send_req(REQ_WRITE, 4'd7,  {$urandom, $urandom});
        send_req(REQ_READ,  4'd1,  64'h0);

        // Alternate between filling to the top and draining to the bottom.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n >= CALM_FROM) calm = 1'b1;
            if (filling && sb.held >= DEPTH - 4) filling = 1'b0;
            if (!filling && sb.held <= 4) filling = 1'b1;
            pick = $urandom_range(0, 99);
            if (filling) begin
                kind = (pick < 75) ? REQ_WRITE : (pick < 85) ? REQ_READ :
                       (pick < 95) ? REQ_PEEK : REQ_SKIP;
            end else begin
                kind = (pick < 10) ? REQ_WRITE : (pick < 55) ? REQ_READ :
                       (pick < 75) ? REQ_PEEK : REQ_SKIP;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                len = 4'($urandom_range(0, 7));
                if (len != 0) len = len + 4'd8;
            end else if (pick < 60) begin
                len = 4'd8;
            end else begin
                len = 4'($urandom_range(1, 8));
            end
            pick = $urandom_range(0, 19);
            wdat = (pick == 0) ? 64'h0 : (pick == 1) ? '1 : {$urandom, $urandom};
            send_req(kind, len, wdat);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);

        $display("Covered %0d requests: %0d write, %0d read, %0d peek, %0d skip, %0d bad length.",
                 sent, sb.n_kind[REQ_WRITE], sb.n_kind[REQ_READ], sb.n_kind[REQ_PEEK],
                 sb.n_kind[REQ_SKIP], sb.n_bad_len);
        $display("Checked %0d result beats; queue full %0d times, %0d writes refused, %0d empty hits.",
                 sb.beats, sb.n_full, sb.n_refused, sb.n_empty);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
